@@ hdl/nbs_pkg.sv @@
package nbs_pkg;

  // Field widths fixed by the item format
  localparam int PIXEL_W = 8;
  localparam int SUM_W   = 12;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 6;
  localparam int FW_W    = 7;
  localparam int CFG_W   = 10;
  localparam int NSLOT   = 4;

  localparam int DEF_MAX_COLS = 64;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(10);
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = ROW_W'(10);

  // Position flags of one pixel within the frame
  typedef struct packed {
    logic has_up;    // row >= 1
    logic has_up2;   // row >= 2
    logic has_left;  // col >= 1
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

@@ hdl/neighborhood_sum_3x3_unit.sv @@
// 3x3 neighborhood sum over a raster-order pixel stream, zero padded at the
// frame border.
// Input channel s_axis: one 8-bit pixel per item. Output channel m_axis: one
// window sum per item with its row and column; tlast marks the last result
// caused by one pixel, tuser marks the final result of the frame.
// The sum for pixel (r-1,c-1) follows pixel (r,c); the last column and the
// last row add extra results, so one pixel causes 0 to 4 results.
// Configuration port: cfg_index 0 writes frame_width, 1 writes frame_height;
// cfg_ready is always high; write only while the block is idle.
// A pixel passes the line store read, then the window update into the result
// register, from which its first result is offered.
// Throughput: one pixel per cycle while each causes at most one result and
// m_axis does not stall; a pixel with several results holds the input until
// its last is taken; the result register hands out one result per cycle while m_axis is ready.
// Reset clears the counters, window and result register; the line stores are
// not cleared and need no clearing pass, rows above the frame read as zero.
// When m_axis stalls, the result register holds and the input stops after
// the one pixel waiting at the line store output.
module neighborhood_sum_3x3_unit #(
  parameter int MAX_COLS = nbs_pkg::DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [11:0] window_sum, [21:12] out_row, [27:22] out_col
  output logic        m_axis_tlast,    // run_last
  output logic        m_axis_tuser     // [0] frame_end
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int CMP_W  = (ADDR_W > nbs_pkg::FW_W ? ADDR_W : nbs_pkg::FW_W) + 1;
  localparam int PW     = nbs_pkg::PIXEL_W;
  localparam int RW     = nbs_pkg::ROW_W;

  logic [nbs_pkg::FW_W-1:0] frame_width;
  logic [RW-1:0]            frame_height;
  logic [ADDR_W-1:0]        col;
  logic [RW-1:0]            row;

  logic [CMP_W-1:0]         w_ext;
  logic [CMP_W-1:0]         w_eff;
  logic [RW:0]              h_eff;
  nbs_pkg::pos_flags_t      flags;
  logic                     accept;

  logic                     s2_valid;
  logic [PW-1:0]            s2_px;
  logic [ADDR_W-1:0]        s2_col;
  logic [RW-1:0]            s2_row;
  nbs_pkg::pos_flags_t      s2_flags;
  logic                     s2_fwd;
  logic [PW-1:0]            s2_fwd_old;
  logic [PW-1:0]            s2_fwd_new;
  logic                     s2_adv;

  logic [2*PW-1:0]          rd_data;
  logic [PW-1:0]            raw_old;
  logic [PW-1:0]            raw_new;
  logic [PW-1:0]            up1;
  logic [PW-1:0]            up2;
  logic [nbs_pkg::SUM_W-1:0] sums [nbs_pkg::NSLOT];
  logic                     em_free;
  logic [nbs_pkg::SUM_W-1:0] out_sum;
  logic [RW-1:0]            out_row;
  logic [nbs_pkg::COL_W-1:0] out_col;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= nbs_pkg::FRAME_WIDTH_RST;
      frame_height <= nbs_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nbs_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[nbs_pkg::FW_W-1:0];
        nbs_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, width capped at the line depth
  always_comb begin
    w_ext = CMP_W'(frame_width);
    if (w_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_ext > CMP_W'(MAX_COLS)) begin
      w_eff = CMP_W'(MAX_COLS);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (frame_height == '0) ? (RW + 1)'(1) : {1'b0, frame_height};
  end

  // Position of the incoming pixel
  assign flags.has_up   = (row != '0);
  assign flags.has_up2  = (row > RW'(1));
  assign flags.has_left = (col != '0);
  assign flags.last_col = (CMP_W'(col) + CMP_W'(1) >= w_eff);
  assign flags.last_row = ((RW + 1)'(row) + (RW + 1)'(1) >= h_eff);

  assign s_axis_tready = !s2_valid || s2_adv;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Advance the raster counters per taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (flags.last_col) begin
        col <= '0;
        row <= flags.last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + ADDR_W'(1);
      end
    end
  end

  // Line store: read at accept, write back when the item leaves stage 2
  nbs_line_store #(
    .MAX_COLS (MAX_COLS)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s2_adv),
    .wr_addr (s2_col),
    .wr_data ({raw_new, s2_px})
  );

  // Take forwarded data when the previous item wrote this column on the read edge
  assign raw_old = s2_fwd ? s2_fwd_old : rd_data[2*PW-1:PW];
  assign raw_new = s2_fwd ? s2_fwd_new : rd_data[PW-1:0];
  assign up2     = s2_flags.has_up2 ? raw_old : '0;
  assign up1     = s2_flags.has_up  ? raw_new : '0;

  assign s2_adv = s2_valid & em_free;

  // Stage 2 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_px      <= s_axis_tdata;
      s2_col     <= col;
      s2_row     <= row;
      s2_flags   <= flags;
      s2_fwd     <= s2_adv && (s2_col == col);
      s2_fwd_old <= raw_new;
      s2_fwd_new <= s2_px;
    end
  end

  nbs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (s2_adv),
    .clear   (!s2_flags.has_left),
    .up2     (up2),
    .up1     (up1),
    .px      (s2_px),
    .sums    (sums)
  );

  nbs_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (s2_adv),
    .sums          (sums),
    .row           (s2_row),
    .col           (nbs_pkg::COL_W'(s2_col)),
    .flags         (s2_flags),
    .free          (em_free),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_sum       (out_sum),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_last      (m_axis_tlast),
    .out_frame_end (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, out_col, out_row, out_sum};

endmodule

@@ hdl/nbs_line_store.sv @@
module nbs_line_store #(
  parameter int MAX_COLS = nbs_pkg::DEF_MAX_COLS
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_COLS)-1:0]        rd_addr,
  output logic [2*nbs_pkg::PIXEL_W-1:0]      rd_data,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_COLS)-1:0]        wr_addr,
  input  logic [2*nbs_pkg::PIXEL_W-1:0]      wr_data
);

  // Both line stores share one entry per column: {older row, newer row}
  logic [2*nbs_pkg::PIXEL_W-1:0] mem [MAX_COLS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/nbs_window.sv @@
module nbs_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          clear,
  input  logic [nbs_pkg::PIXEL_W-1:0]   up2,
  input  logic [nbs_pkg::PIXEL_W-1:0]   up1,
  input  logic [nbs_pkg::PIXEL_W-1:0]   px,
  output logic [nbs_pkg::SUM_W-1:0]     sums [nbs_pkg::NSLOT]
);

  logic [nbs_pkg::PIXEL_W-1:0] win      [3][3];
  logic [nbs_pkg::PIXEL_W-1:0] win_next [3][3];
  logic [nbs_pkg::SUM_W-1:0]   col_full [3];
  logic [nbs_pkg::SUM_W-1:0]   col_low  [3];

  // Shift the window left, clear at the start of a row, load the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = clear ? '0 : win[i][1];
      win_next[i][1] = clear ? '0 : win[i][2];
    end
    win_next[0][2] = up2;
    win_next[1][2] = up1;
    win_next[2][2] = px;
  end

  // Column sums over all three rows and over the lower two rows
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      col_low[j]  = nbs_pkg::SUM_W'(win_next[1][j]) + nbs_pkg::SUM_W'(win_next[2][j]);
      col_full[j] = col_low[j] + nbs_pkg::SUM_W'(win_next[0][j]);
    end
  end

  // One sum per result slot, in raster order of the results
  assign sums[0] = col_full[0] + col_full[1] + col_full[2];
  assign sums[1] = col_full[1] + col_full[2];
  assign sums[2] = col_low[0] + col_low[1] + col_low[2];
  assign sums[3] = col_low[1] + col_low[2];

  // Hold the window between items
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (advance) begin
      win <= win_next;
    end
  end

endmodule

@@ hdl/nbs_emit.sv @@
module nbs_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [nbs_pkg::SUM_W-1:0]     sums [nbs_pkg::NSLOT],
  input  logic [nbs_pkg::ROW_W-1:0]     row,
  input  logic [nbs_pkg::COL_W-1:0]     col,
  input  nbs_pkg::pos_flags_t           flags,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nbs_pkg::SUM_W-1:0]     out_sum,
  output logic [nbs_pkg::ROW_W-1:0]     out_row,
  output logic [nbs_pkg::COL_W-1:0]     out_col,
  output logic                          out_last,
  output logic                          out_frame_end
);

  logic [nbs_pkg::NSLOT-1:0] mask_in;
  logic [nbs_pkg::NSLOT-1:0] mask;
  logic [nbs_pkg::SUM_W-1:0] sum_q [nbs_pkg::NSLOT];
  logic [nbs_pkg::ROW_W-1:0] row_q;
  logic [nbs_pkg::COL_W-1:0] col_q;
  logic                      fend_q;
  logic [1:0]                sel;
  logic                      single;
  logic                      take;

  // Results an item causes: two for the row above, two for its own row
  assign mask_in = {flags.last_row & flags.last_col,
                    flags.last_row & flags.has_left,
                    flags.has_up   & flags.last_col,
                    flags.has_up   & flags.has_left};

  // Pick the lowest pending slot
  always_comb begin
    sel = 2'd3;
    for (int k = nbs_pkg::NSLOT - 1; k >= 0; k--) begin
      if (mask[k]) begin
        sel = 2'(k);
      end
    end
  end

  assign single = ((mask & (mask - nbs_pkg::NSLOT'(1))) == '0);
  assign take   = out_valid & out_ready;
  assign free   = !out_valid || (out_ready && single);

  assign out_sum       = sum_q[sel];
  assign out_row       = sel[1] ? row_q : row_q - nbs_pkg::ROW_W'(1);
  assign out_col       = sel[0] ? col_q : col_q - nbs_pkg::COL_W'(1);
  assign out_last      = single;
  assign out_frame_end = single & fend_q;

  // Hold results, drop each slot as it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mask      <= '0;
    end else if (load) begin
      out_valid <= |mask_in;
      mask      <= mask_in;
    end else if (take) begin
      mask <= mask & (mask - nbs_pkg::NSLOT'(1));
      if (single) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the loaded item
  always_ff @(posedge clk) begin
    if (load) begin
      sum_q  <= sums;
      row_q  <= row;
      col_q  <= col;
      fend_q <= flags.last_row & flags.last_col;
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // One window sum as it leaves the block
  typedef struct packed {
    logic [nbs_pkg::SUM_W-1:0] sum;
    logic [nbs_pkg::ROW_W-1:0] row;
    logic [nbs_pkg::COL_W-1:0] col;
    logic                      run_last;
    logic                      frame_end;
  } window_sum_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = nbs_pkg::REG_FRAME_WIDTH;
  logic [9:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] pixel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [11:0] window_sum, [21:12] out_row, [27:22] out_col
  logic        m_axis_tlast;          // run_last
  logic        m_axis_tuser;          // [0] frame_end

  // Shadow of the block state
  bit [nbs_pkg::FW_W-1:0]  cfg_width  = nbs_pkg::FRAME_WIDTH_RST;
  bit [nbs_pkg::ROW_W-1:0] cfg_height = nbs_pkg::FRAME_HEIGHT_RST;
  bit [7:0]                line_prev2 [nbs_pkg::DEF_MAX_COLS];
  bit [7:0]                line_prev1 [nbs_pkg::DEF_MAX_COLS];
  bit [7:0]                win [3][3];
  bit [nbs_pkg::ROW_W-1:0] row_pos = '0;
  bit [nbs_pkg::COL_W-1:0] col_pos = '0;

  window_sum_t      pending_sums [$];
  window_sum_t      want;
  window_sum_t      seen;

  int unsigned      src_gap_pct = 0;
  int unsigned      sink_stall_pct = 0;
  int unsigned      px_count = 0;
  int unsigned      err_cnt = 0;
  int unsigned      cycle_cnt = 0;

  neighborhood_sum_3x3_unit dut (.*);

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned active_width();
    int unsigned w;
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > nbs_pkg::DEF_MAX_COLS) w = nbs_pkg::DEF_MAX_COLS;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = cfg_height;
    if (h == 0) h = 1;
    return h;
  endfunction

  // Sum the window from row r0 and column c0 to the lower-right corner
  function automatic int unsigned window_total(input int r0, input int c0);
    int unsigned s;
    s = 0;
    for (int i = r0; i < 3; i++)
      for (int j = c0; j < 3; j++)
        s += win[i][j];
    return s;
  endfunction

  function automatic void queue_sum(input int unsigned s, input int unsigned row,
                                    input int unsigned col);
    pending_sums.push_back('{sum: nbs_pkg::SUM_W'(s), row: nbs_pkg::ROW_W'(row),
                             col: nbs_pkg::COL_W'(col), run_last: 1'b0, frame_end: 1'b0});
  endfunction

  // Advance the shadow state by one pixel and queue the sums it releases
  function automatic void predict_window_sums(input bit [7:0] px);
    int unsigned w, h, r, c, n;
    bit lc, lr;
    bit [7:0] above2, above1;
    w = active_width();
    h = active_height();
    r = row_pos;
    c = col_pos;
    n = 0;
    lc = (c + 1 >= w);
    lr = (r + 1 >= h);
    // rows above the frame read as zero
    above2 = (r >= 2) ? line_prev2[c] : 8'd0;
    above1 = (r >= 1) ? line_prev1[c] : 8'd0;

    // clear the window at row start, then shift in the new column
    if (c == 0) win = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = px;

    if (r >= 1) begin
      if (c >= 1) begin
        queue_sum(window_total(0, 0), r - 1, c - 1);
        n++;
      end
      if (lc) begin
        queue_sum(window_total(0, 1), r - 1, c);
        n++;
      end
    end
    if (lr) begin
      if (c >= 1) begin
        queue_sum(window_total(1, 0), r, c - 1);
        n++;
      end
      if (lc) begin
        queue_sum(window_total(1, 1), r, c);
        n++;
      end
    end
    if (n != 0) begin
      pending_sums[pending_sums.size() - 1].run_last = 1'b1;
      if (lr && lc) pending_sums[pending_sums.size() - 1].frame_end = 1'b1;
    end

    line_prev2[c] = line_prev1[c];
    line_prev1[c] = px;

    // wrap counters, a counter past the frame edge counts as the edge
    if (lc) begin
      col_pos = '0;
      row_pos = lr ? '0 : nbs_pkg::ROW_W'(r + 1);
    end else begin
      col_pos = nbs_pkg::COL_W'(c + 1);
    end
  endfunction

  // Compare each result with the oldest expected sum
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen = '{sum: m_axis_tdata[11:0], row: m_axis_tdata[21:12], col: m_axis_tdata[27:22],
               run_last: m_axis_tlast, frame_end: m_axis_tuser};
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result sum %0d row %0d col %0d last %0b end %0b",
                 $time, seen.sum, seen.row, seen.col, seen.run_last, seen.frame_end);
        err_cnt++;
      end else begin
        want = pending_sums.pop_front();
        if (seen !== want) begin
          $display("%0t: mismatch: expected sum %0d row %0d col %0d last %0b end %0b",
                   $time, want.sum, want.row, want.col, want.run_last, want.frame_end);
          $display("%0t:           actual   sum %0d row %0d col %0d last %0b end %0b",
                   $time, seen.sum, seen.row, seen.col, seen.run_last, seen.frame_end);
          err_cnt++;
        end
      end
    end
  end

  // Send one pixel, idling at random before it
  task automatic push_pixel(input bit [7:0] px);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_window_sums(px);
    px_count++;
  endtask

  // Hold the input until every expected sum is out and the pipe is empty
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input nbs_pkg::reg_idx_t idx, input logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == nbs_pkg::REG_FRAME_WIDTH) cfg_width = val[nbs_pkg::FW_W-1:0];
    else cfg_height = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send random pixels until the counters return to the frame start
  task automatic finish_frame();
    do push_pixel(8'($urandom_range(255)));
    while (row_pos != 0 || col_pos != 0);
  endtask

  // Reset geometry, then shrink both sizes mid-row so the column is already past the edge
  task automatic test_reset_geometry();
    repeat (nbs_pkg::FRAME_WIDTH_RST + 3) push_pixel(8'($urandom_range(255)));
    drain_results();
    write_reg(nbs_pkg::REG_FRAME_WIDTH, 10'd2);
    write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'd2);
    finish_frame();
  endtask

  // Smallest frame with a full window, at full brightness: largest sum, four results on the last pixel
  task automatic test_full_window();
    drain_results();
    write_reg(nbs_pkg::REG_FRAME_WIDTH, 10'd3);
    write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'd3);
    repeat (9) push_pixel(8'hFF);
  endtask

  // Zero width and height act as one; upper data bits of the width write are dropped
  task automatic test_degenerate_sizes();
    drain_results();
    write_reg(nbs_pkg::REG_FRAME_WIDTH, 10'b111_0000000);
    write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'd0);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    drain_results();
    write_reg(nbs_pkg::REG_FRAME_WIDTH, 10'b001_0000001);
    write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'd3);
    push_pixel(8'hFF);
    push_pixel(8'h00);
    push_pixel(8'hFF);
  endtask

  // Oversize width clamps to the line depth; tallest height, cut short mid-row
  task automatic test_widest_rows();
    drain_results();
    write_reg(nbs_pkg::REG_FRAME_WIDTH, 10'h3FF);
    write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'h3FF);
    repeat (2 * nbs_pkg::DEF_MAX_COLS - 4) push_pixel(8'($urandom_range(255)));
    drain_results();
    write_reg(nbs_pkg::REG_FRAME_WIDTH, 10'(nbs_pkg::DEF_MAX_COLS));
    write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'd1);
    finish_frame();
  endtask

  // Random small frames, now and then resized mid-frame; width only shrinks inside a frame
  task automatic test_random_frames(input int unsigned budget);
    int unsigned start, cut, k;
    start = px_count;
    while (px_count - start < budget) begin
      if (px_count == start || $urandom_range(1) == 1) begin
        drain_results();
        write_reg(nbs_pkg::REG_FRAME_WIDTH, {3'($urandom_range(7)), 7'($urandom_range(12))});
        write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'($urandom_range(6)));
      end
      cut = $urandom_range(4 * active_width() * active_height(), 1);
      k = 0;
      do begin
        if (k == cut) begin
          drain_results();
          if ($urandom_range(1) == 1)
            write_reg(nbs_pkg::REG_FRAME_HEIGHT, 10'($urandom_range(row_pos + 2)));
          else
            write_reg(nbs_pkg::REG_FRAME_WIDTH,
                      {3'($urandom_range(7)), 7'($urandom_range(active_width()))});
        end
        push_pixel(8'($urandom_range(255)));
        k++;
      end while (row_pos != 0 || col_pos != 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_gap_pct    = 7;
    sink_stall_pct = 55;
    test_reset_geometry();
    test_full_window();
    test_degenerate_sizes();
    test_random_frames(10);

    drain_results();
    src_gap_pct    = 55;
    sink_stall_pct = 7;
    test_widest_rows();
    test_random_frames(10);

    drain_results();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_frames(12);

    drain_results();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
